FILE: rtl/srsw_pkg.sv
`default_nettype none

package srsw_pkg;

   // pointer and field widths
   localparam int PTR_W   = 9;
   localparam int SEQ_W   = 8;
   localparam int OP_W    = 2;
   localparam int WIN_W   = 5;
   localparam int CSR_A_W = 1;
   localparam int CSR_D_W = 9;

   typedef logic [OP_W-1:0]    op_type;
   typedef logic [PTR_W-1:0]   ptr_type;
   typedef logic [SEQ_W-1:0]   seq_type;
   typedef logic [CSR_A_W-1:0] csr_addr_type;
   typedef logic [CSR_D_W-1:0] csr_data_type;

   // event codes (code 3 is unused)
   localparam op_type OP_START   = 2'd0;
   localparam op_type OP_ACK     = 2'd1;
   localparam op_type OP_TIMEOUT = 2'd2;

   // register indexes
   localparam csr_addr_type REG_WIN_LEN      = 1'd0;
   localparam csr_addr_type REG_TOTAL_FRAMES = 1'd1;

   localparam logic [WIN_W-1:0] WINDOW_RESET = 5'd4;
   localparam ptr_type          TOTAL_RESET  = 9'd8;

endpackage

`default_nettype wire

FILE: rtl/srsw_if.sv
`default_nettype none

interface srsw_req_if
   import srsw_pkg::*;
   ();
   logic    valid;
   logic    ready;
   op_type  operation;
   seq_type ack_seq;

   modport source (output valid, output operation, output ack_seq, input ready);
   modport sink   (input valid, input operation, input ack_seq, output ready);
endinterface

interface srsw_rsp_if
   import srsw_pkg::*;
   ();
   logic    valid;
   logic    ready;
   logic    frame_valid;
   seq_type frame_seq;
   logic    is_resend;
   logic    ack_ignored;
   logic    all_acked;
   ptr_type window_base;
   logic    last;

   modport source (output valid, output frame_valid, output frame_seq, output is_resend,
                   output ack_ignored, output all_acked, output window_base, output last,
                   input ready);
   modport sink   (input valid, input frame_valid, input frame_seq, input is_resend,
                   input ack_ignored, input all_acked, input window_base, input last,
                   output ready);
endinterface

interface srsw_csr_if
   import srsw_pkg::*;
   ();
   logic         valid;
   logic         ready;
   csr_addr_type addr;
   csr_data_type wdata;

   modport source (output valid, output addr, output wdata, input ready);
   modport sink   (input valid, input addr, input wdata, output ready);
endinterface

`default_nettype wire

FILE: rtl/srsw_ram.sv
`default_nettype none

module srsw_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/selective_repeat_sender_window.sv
// Selective-repeat ARQ sender window control.
// req_ch: one item per event (operation: start, ack, timeout; ack_seq for an ack).
// rsp_ch: the frames to send for that event, each carrying the status fields
//   (ack_ignored, all_acked, window_base); last marks the event's final item.
//   An event that sends nothing gives one item with frame_valid low.
// csr_ch: window length (index 0) and total_frames (index 1); always ready; to be
//   written only while no event is in progress, which the block does not enforce.
// One event at a time; req_ch.ready is low while busy.
//   start: send the new frames that fit in the window and below the total.
//   ack: mark the frame in the ack map, slide the base over acked frames, then
//        as start; an ignored ack goes straight to the sending of new frames.
//   timeout: scan the map from base to next and resend each unacked frame,
//        then close the scan with the last item.
//   The ack map is one RAM port pair; each map lookup is a registered read,
//   so the slide and the resend scan each read, then check, per frame.
// Reset: pointers clear, registers take 4 / 8, then a clearing pass writes
//   every ack map entry, during which no event is accepted.
// Receiver stall: results sit in the output register; the sequencer waits
//   there and resumes when rsp_ch.ready returns.
`default_nettype none

module selective_repeat_sender_window
   import srsw_pkg::*;
#(
   parameter int MAX_FRAMES = 256,
   parameter int MAX_WINDOW = 16
) (
   input wire logic  clock,
   input wire logic  reset,
   srsw_req_if.sink  req_ch,
   srsw_rsp_if.source rsp_ch,
   srsw_csr_if.sink  csr_ch
);

   localparam int AW      = $clog2(MAX_FRAMES);
   // total_frames is 9 bits and the window register 5 bits, so caps above these never bind
   localparam int TOT_CAP = (MAX_FRAMES > 511) ? 511 : MAX_FRAMES;
   localparam int WIN_CAP = (MAX_WINDOW > 31) ? 31 : MAX_WINDOW;

   // sequencer states
   localparam logic [3:0] ST_CLEAR     = 4'd0;
   localparam logic [3:0] ST_IDLE      = 4'd1;
   localparam logic [3:0] ST_SLIDE_RD  = 4'd2;
   localparam logic [3:0] ST_SLIDE_CHK = 4'd3;
   localparam logic [3:0] ST_POST      = 4'd4;
   localparam logic [3:0] ST_FILL      = 4'd5;
   localparam logic [3:0] ST_SCAN_RD   = 4'd6;
   localparam logic [3:0] ST_SCAN_CHK  = 4'd7;
   localparam logic [3:0] ST_SCAN_EMIT = 4'd8;
   localparam logic [3:0] ST_SCAN_END  = 4'd9;

   logic [3:0]       state_ff, state_in;
   ptr_type          base_ff, base_in;
   ptr_type          next_ff, next_in;
   ptr_type          scan_ff, scan_in;
   ptr_type          pend_ff, pend_in;
   logic             have_pend_ff, have_pend_in;
   logic             ignored_ff, ignored_in;
   logic [AW-1:0]    clr_cnt_ff, clr_cnt_in;
   logic [WIN_W-1:0] win_ff;
   ptr_type          tot_ff;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_frame_valid_ff, rsp_frame_valid_in;
   seq_type          rsp_seq_ff, rsp_seq_in;
   logic             rsp_resend_ff, rsp_resend_in;
   logic             rsp_ignored_ff, rsp_ignored_in;
   logic             rsp_all_acked_ff, rsp_all_acked_in;
   ptr_type          rsp_base_ff, rsp_base_in;
   logic             rsp_last_ff, rsp_last_in;

   // effective config
   ptr_type          win_eff, tot_eff;
   logic [PTR_W:0]   lim, endp;

   // shared incrementer and comparator
   ptr_type          inc_src, inc_res;
   logic [PTR_W:0]   cmp_a, cmp_b;
   logic             lt;

   // emit request
   logic             emit, ev_valid, ev_resend, ev_last;
   ptr_type          ev_seq;
   logic             out_free;

   // ack map port
   logic             wr_en, wr_data, rd_en, rd_data;
   logic [AW-1:0]    wr_addr, rd_addr;

   srsw_ram #(.WIDTH(1), .DEPTH(MAX_FRAMES)) u_ack_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // window 0 acts as 1, window above the cap acts as the cap, totals clipped to the map size
   always_comb begin
      if (win_ff == '0) begin
         win_eff = ptr_type'(1);
      end else if (win_ff > WIN_W'(WIN_CAP)) begin
         win_eff = ptr_type'(WIN_CAP);
      end else begin
         win_eff = ptr_type'(win_ff);
      end
      tot_eff = (tot_ff > ptr_type'(TOT_CAP)) ? ptr_type'(TOT_CAP) : tot_ff;
      lim     = {1'b0, base_ff} + {1'b0, win_eff};
      endp    = (lim < {1'b0, tot_eff}) ? lim : {1'b0, tot_eff};
   end

   always_comb begin
      unique case (state_ff)
         ST_SLIDE_RD, ST_SLIDE_CHK: inc_src = base_ff;
         ST_FILL:                   inc_src = next_ff;
         default:                   inc_src = scan_ff;
      endcase
      inc_res = inc_src + ptr_type'(1);
   end

   always_comb begin
      unique case (state_ff)
         ST_SLIDE_RD: begin
            cmp_a = {1'b0, base_ff};
            cmp_b = {1'b0, tot_eff};
         end
         ST_POST: begin
            cmp_a = {1'b0, next_ff};
            cmp_b = {1'b0, base_ff};
         end
         ST_FILL: begin
            cmp_a = {1'b0, next_ff};
            cmp_b = endp;
         end
         default: begin
            cmp_a = {1'b0, scan_ff};
            cmp_b = {1'b0, next_ff};
         end
      endcase
      lt = cmp_a < cmp_b;
   end

   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      base_in      = base_ff;
      next_in      = next_ff;
      scan_in      = scan_ff;
      pend_in      = pend_ff;
      have_pend_in = have_pend_ff;
      ignored_in   = ignored_ff;
      clr_cnt_in   = clr_cnt_ff;
      emit         = 1'b0;
      ev_valid     = 1'b0;
      ev_seq       = '0;
      ev_resend    = 1'b0;
      ev_last      = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = clr_cnt_ff;
      wr_data      = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = (state_ff == ST_SLIDE_RD) ? AW'(base_ff) : AW'(scan_ff);

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en      = 1'b1;
            clr_cnt_in = clr_cnt_ff + AW'(1);
            if (clr_cnt_ff == AW'(MAX_FRAMES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_ch.valid) begin
               ignored_in   = 1'b0;
               have_pend_in = 1'b0;
               scan_in      = base_ff;
               case (req_ch.operation)
                  OP_START: begin
                     state_in = ST_FILL;
                  end
                  OP_ACK: begin
                     if ({1'b0, req_ch.ack_seq} >= tot_eff) begin
                        ignored_in = 1'b1;
                        state_in   = ST_FILL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = AW'(req_ch.ack_seq);
                        wr_data  = 1'b1;
                        state_in = ST_SLIDE_RD;
                     end
                  end
                  OP_TIMEOUT: begin
                     state_in = ST_SCAN_RD;
                  end
                  default: begin
                     state_in = ST_SCAN_END;
                  end
               endcase
            end
         end
         ST_SLIDE_RD: begin
            if (lt) begin
               rd_en    = 1'b1;
               state_in = ST_SLIDE_CHK;
            end else begin
               state_in = ST_POST;
            end
         end
         ST_SLIDE_CHK: begin
            if (rd_data) begin
               base_in  = inc_res;
               state_in = ST_SLIDE_RD;
            end else begin
               state_in = ST_POST;
            end
         end
         ST_POST: begin
            // acked-but-unsent frames are skipped
            if (lt) begin
               next_in = base_ff;
            end
            state_in = ST_FILL;
         end
         ST_FILL: begin
            if (out_free) begin
               emit    = 1'b1;
               ev_last = 1'b1;
               if (lt) begin
                  ev_valid = 1'b1;
                  ev_seq   = next_ff;
                  ev_last  = ({1'b0, inc_res} == endp);
                  next_in  = inc_res;
               end
               if (ev_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SCAN_RD: begin
            if (lt) begin
               rd_en    = 1'b1;
               state_in = ST_SCAN_CHK;
            end else begin
               state_in = ST_SCAN_END;
            end
         end
         ST_SCAN_CHK: begin
            // one-behind: a frame is sent once the next one (or the end) is known
            if (!rd_data) begin
               if (have_pend_ff) begin
                  state_in = ST_SCAN_EMIT;
               end else begin
                  pend_in      = scan_ff;
                  have_pend_in = 1'b1;
                  scan_in      = inc_res;
                  state_in     = ST_SCAN_RD;
               end
            end else begin
               scan_in  = inc_res;
               state_in = ST_SCAN_RD;
            end
         end
         ST_SCAN_EMIT: begin
            if (out_free) begin
               emit      = 1'b1;
               ev_valid  = 1'b1;
               ev_seq    = pend_ff;
               ev_resend = 1'b1;
               pend_in   = scan_ff;
               scan_in   = inc_res;
               state_in  = ST_SCAN_RD;
            end
         end
         ST_SCAN_END: begin
            if (out_free) begin
               emit      = 1'b1;
               ev_valid  = have_pend_ff;
               ev_seq    = have_pend_ff ? pend_ff : '0;
               ev_resend = have_pend_ff;
               ev_last   = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in       = rsp_valid_ff;
      rsp_frame_valid_in = rsp_frame_valid_ff;
      rsp_seq_in         = rsp_seq_ff;
      rsp_resend_in      = rsp_resend_ff;
      rsp_ignored_in     = rsp_ignored_ff;
      rsp_all_acked_in   = rsp_all_acked_ff;
      rsp_base_in        = rsp_base_ff;
      rsp_last_in        = rsp_last_ff;
      if (emit) begin
         rsp_valid_in       = 1'b1;
         rsp_frame_valid_in = ev_valid;
         rsp_seq_in         = ev_seq[SEQ_W-1:0];
         rsp_resend_in      = ev_resend;
         rsp_ignored_in     = ignored_ff;
         rsp_all_acked_in   = (base_ff >= tot_eff);
         rsp_base_in        = base_ff;
         rsp_last_in        = ev_last;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         base_ff      <= '0;
         next_ff      <= '0;
         have_pend_ff <= 1'b0;
         ignored_ff   <= 1'b0;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         win_ff       <= WINDOW_RESET;
         tot_ff       <= TOTAL_RESET;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         next_ff      <= next_in;
         have_pend_ff <= have_pend_in;
         ignored_ff   <= ignored_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_ch.valid) begin
            unique case (csr_ch.addr)
               REG_WIN_LEN:      win_ff <= csr_ch.wdata[WIN_W-1:0];
               REG_TOTAL_FRAMES: tot_ff <= csr_ch.wdata[PTR_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_ff            <= scan_in;
      pend_ff            <= pend_in;
      rsp_frame_valid_ff <= rsp_frame_valid_in;
      rsp_seq_ff         <= rsp_seq_in;
      rsp_resend_ff      <= rsp_resend_in;
      rsp_ignored_ff     <= rsp_ignored_in;
      rsp_all_acked_ff   <= rsp_all_acked_in;
      rsp_base_ff        <= rsp_base_in;
      rsp_last_ff        <= rsp_last_in;
   end

   assign req_ch.ready       = (state_ff == ST_IDLE);
   assign csr_ch.ready       = 1'b1;
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.frame_valid = rsp_frame_valid_ff;
   assign rsp_ch.frame_seq   = rsp_seq_ff;
   assign rsp_ch.is_resend   = rsp_resend_ff;
   assign rsp_ch.ack_ignored = rsp_ignored_ff;
   assign rsp_ch.all_acked   = rsp_all_acked_ff;
   assign rsp_ch.window_base = rsp_base_ff;
   assign rsp_ch.last        = rsp_last_ff;

endmodule

`default_nettype wire

FILE: tb/selective_repeat_sender_window_tb.sv
module selective_repeat_sender_window_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import srsw_pkg::*;

   // block parameters, passed to the instance and used by the predictor
   localparam int N_FRAMES = 256;
   localparam int N_WIN    = 16;

   localparam int CLK_HALF     = 6;
   localparam int RESET_CYCLES = 9;
   // worst case is far below this: ~150 events, each a slide of up to 256
   // frames and 16 frames out under receiver stalls, plus the ack-map
   // clearing pass
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int RANDOM_ITEMS = 128;
   localparam int DRAIN_CYCLES = 64;
   localparam int REPORT_MAX   = 10;

   // event code the block does not define; must give one idle status item
   localparam op_type OP_UNUSED = 2'd3;

   // one item on the result channel
   typedef struct packed {
      logic    frame_valid;
      seq_type frame_seq;
      logic    is_resend;
      logic    ack_ignored;
      logic    all_acked;
      ptr_type window_base;
      logic    last;
   } frame_item_type;

   // receiver back-pressure patterns
   typedef enum logic [1:0] {DRAIN_FREE, DRAIN_RANDOM, DRAIN_STALLS} drain_mode_type;

   // Tracks the sender window and works out which frames each event sends.
   class frame_schedule_type;
      bit [N_FRAMES-1:0] acked;
      int unsigned       base;
      int unsigned       next_seq;
      logic [WIN_W-1:0]  window_reg;
      csr_data_type      total_reg;
      frame_item_type    frames_due[$];
      frame_item_type    batch[$];
      int                mismatches;

      function new();
         acked      = '0;
         base       = 0;
         next_seq   = 0;
         window_reg = WINDOW_RESET;
         total_reg  = TOTAL_RESET;
         mismatches = 0;
      endfunction

      function int unsigned window_eff();
         if (window_reg == 0) return 1;
         if (window_reg > N_WIN) return N_WIN;
         return window_reg;
      endfunction

      function int unsigned total_eff();
         return (total_reg > N_FRAMES) ? N_FRAMES : total_reg;
      endfunction

      function void write_reg(csr_addr_type idx, csr_data_type value);
         case (idx)
            REG_WIN_LEN:      window_reg = value[WIN_W-1:0];
            REG_TOTAL_FRAMES: total_reg = value;
            default: ;
         endcase
      endfunction

      // first sends for every new frame that fits below base+window and total
      function void fill_window();
         int unsigned lim;
         frame_item_type f;
         lim = base + window_eff();
         f   = '0;
         while (next_seq < lim && next_seq < total_eff() && batch.size() < N_WIN) begin
            f.frame_valid = 1'b1;
            f.frame_seq   = next_seq[SEQ_W-1:0];
            batch.push_back(f);
            next_seq++;
         end
      endfunction

      function void post_event(op_type op, seq_type seq);
         int unsigned tot;
         bit          ignored;
         frame_item_type f;
         tot     = total_eff();
         ignored = 1'b0;
         f       = '0;
         batch.delete();
         case (op)
            OP_START: fill_window();
            OP_ACK: begin
               if (seq >= tot) begin
                  ignored = 1'b1;
               end else begin
                  acked[seq] = 1'b1;
                  while (base < tot && acked[base]) base++;
                  if (next_seq < base) next_seq = base;
               end
               fill_window();
            end
            OP_TIMEOUT: begin
               for (int unsigned s = base;
                    s < next_seq && s < N_FRAMES && batch.size() < N_WIN; s++) begin
                  if (!acked[s]) begin
                     f.frame_valid = 1'b1;
                     f.frame_seq   = s[SEQ_W-1:0];
                     f.is_resend   = 1'b1;
                     batch.push_back(f);
                  end
               end
            end
            default: ;
         endcase
         if (batch.size() == 0) batch.push_back('0);
         foreach (batch[i]) begin
            batch[i].ack_ignored = ignored;
            batch[i].all_acked   = (base >= tot);
            batch[i].window_base = base[PTR_W-1:0];
            batch[i].last        = (i == batch.size() - 1);
            frames_due.push_back(batch[i]);
         end
      endfunction

      function string show(frame_item_type f);
         return $sformatf("valid=%0d seq=%0d resend=%0d ign=%0d done=%0d base=%0d last=%0d",
                          f.frame_valid, f.frame_seq, f.is_resend, f.ack_ignored,
                          f.all_acked, f.window_base, f.last);
      endfunction

      function void retire_frame(frame_item_type got);
         frame_item_type want;
         if (frames_due.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) $display("unexpected item: %s", show(got));
            return;
         end
         want = frames_due.pop_front();
         if (got.frame_valid !== want.frame_valid || got.frame_seq !== want.frame_seq ||
             got.is_resend !== want.is_resend || got.ack_ignored !== want.ack_ignored ||
             got.all_acked !== want.all_acked || got.window_base !== want.window_base ||
             got.last !== want.last) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
               $display("item mismatch at %0t", $time);
               $display("  exp: %s", show(want));
               $display("  got: %s", show(got));
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   srsw_req_if req_if ();
   srsw_rsp_if rsp_if ();
   srsw_csr_if csr_if ();

   frame_schedule_type sched;

   int unsigned    cycle_count = 0;
   drain_mode_type rsp_mode    = DRAIN_FREE;
   int unsigned    mode_left   = 0;
   int unsigned    stall_left  = 0;

   selective_repeat_sender_window #(
      .MAX_FRAMES (N_FRAMES),
      .MAX_WINDOW (N_WIN)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_HALF) clock = ~clock;
   end

   // hard stop in case the block hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Result side: check every accepted item, then pick ready for next cycle.
   // The pattern switches between free flow, random drops and long stalls.
   always @(posedge clock) begin : rsp_side
      frame_item_type got;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         got.frame_valid = rsp_if.frame_valid;
         got.frame_seq   = rsp_if.frame_seq;
         got.is_resend   = rsp_if.is_resend;
         got.ack_ignored = rsp_if.ack_ignored;
         got.all_acked   = rsp_if.all_acked;
         got.window_base = rsp_if.window_base;
         got.last        = rsp_if.last;
         sched.retire_frame(got);
      end
      if (mode_left == 0) begin
         rsp_mode  = drain_mode_type'($urandom_range(0, 2));
         mode_left = $urandom_range(20, 200);
      end else begin
         mode_left--;
      end
      case (rsp_mode)
         DRAIN_FREE:   rsp_if.ready <= 1'b1;
         DRAIN_RANDOM: rsp_if.ready <= ($urandom_range(0, 3) != 0);
         default: begin
            if (stall_left != 0) begin
               stall_left--;
               rsp_if.ready <= 1'b0;
            end else begin
               rsp_if.ready <= 1'b1;
               if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(2, 12);
            end
         end
      endcase
   end

   // Present one event and hold it until the block takes it. Valid is left
   // high so a following event goes out back to back.
   task automatic send_event(op_type op, seq_type seq);
      req_if.valid     <= 1'b1;
      req_if.operation <= op;
      req_if.ack_seq   <= seq;
      @(posedge clock);
      while (req_if.ready !== 1'b1) @(posedge clock);
      sched.post_event(op, seq);
   endtask

   // sender gap
   task automatic hold_off(int unsigned cycles);
      req_if.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Block is idle once every owed item is out and it takes events again;
   // after reset this also covers the ack-map clearing pass.
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (sched.frames_due.size() != 0 || req_if.ready !== 1'b1) @(posedge clock);
   endtask

   task automatic write_csr(csr_addr_type idx, csr_data_type value);
      csr_if.valid <= 1'b1;
      csr_if.addr  <= idx;
      csr_if.wdata <= value;
      @(posedge clock);
      while (csr_if.ready !== 1'b1) @(posedge clock);
      sched.write_reg(idx, value);
   endtask

   task automatic configure(logic [WIN_W-1:0] win, csr_data_type total);
      wait_idle();
      write_csr(REG_WIN_LEN, csr_data_type'(win));
      write_csr(REG_TOTAL_FRAMES, total);
      csr_if.valid <= 1'b0;
   endtask

   initial begin
      int unsigned      counted;
      int unsigned      burst_left;
      int unsigned      gap;
      int unsigned      pick;
      int unsigned      tot_pick;
      int unsigned      phase_len;
      int unsigned      holes[$];
      bit               no_gaps;
      op_type           op;
      seq_type          seq;
      logic [WIN_W-1:0] win;

      sched = new();
      reset            <= 1'b1;
      req_if.valid     <= 1'b0;
      req_if.operation <= OP_START;
      req_if.ack_seq   <= '0;
      csr_if.valid     <= 1'b0;
      csr_if.addr      <= REG_WIN_LEN;
      csr_if.wdata     <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // ---- directed: reset registers (window 4, total 8) ----
      wait_idle();
      send_event(OP_START, 8'd0);     // frames 0..3
      send_event(OP_ACK, 8'd0);       // base slides to 1, frame 4 goes out
      send_event(OP_ACK, 8'd2);       // out of order: base stays, nothing sent
      send_event(OP_TIMEOUT, 8'd0);   // resend the holes 1, 3, 4
      send_event(OP_ACK, 8'd8);       // ack equal to total: flagged, ignored
      send_event(OP_ACK, 8'd255);     // far out of range: ignored
      send_event(OP_UNUSED, 8'hAA);   // undefined code: status only
      send_event(OP_ACK, 8'd1);       // base jumps to 3, frames 5, 6
      send_event(OP_ACK, 8'd7);       // ack of a frame never sent
      send_event(OP_ACK, 8'd3);
      send_event(OP_ACK, 8'd4);
      send_event(OP_ACK, 8'd5);
      send_event(OP_ACK, 8'd6);       // slides over 7 to the total
      send_event(OP_START, 8'd0);     // transfer done: nothing to send
      send_event(OP_TIMEOUT, 8'd0);

      // window above the max acts as max, total above the max acts as max
      configure(5'd31, 9'd511);
      send_event(OP_START, 8'd0);     // full window of 16 first sends
      send_event(OP_TIMEOUT, 8'd0);   // longest resend run

      // window 0 acts as 1, total 0 is an empty transfer
      configure(5'd0, 9'd0);
      send_event(OP_ACK, 8'd0);       // every ack is out of range now
      send_event(OP_START, 8'd0);

      configure(5'd16, 9'd256);
      send_event(OP_ACK, 8'd8);
      send_event(OP_TIMEOUT, 8'd0);
      send_event(OP_ACK, 8'd128);     // well ahead of next

      // ---- random phases: new registers, then a run of events ----
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 9);
         if (pick == 0)      win = 5'd0;
         else if (pick == 1) win = WIN_W'($urandom_range(N_WIN + 1, 31));
         else                win = WIN_W'($urandom_range(1, N_WIN));
         // mostly a total a bit past the base so the transfer stays live
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            tot_pick = $urandom_range(N_FRAMES + 1, 511);
         end else if (pick == 1) begin
            tot_pick = $urandom_range(0, sched.base);
         end else begin
            tot_pick = sched.base + $urandom_range(4, 40);
            if (tot_pick > N_FRAMES) tot_pick = N_FRAMES;
         end
         configure(win, csr_data_type'(tot_pick));

         no_gaps    = ($urandom_range(0, 3) == 0);
         burst_left = $urandom_range(1, 12);
         phase_len  = $urandom_range(10, 30);
         for (int unsigned n = 0; n < phase_len && counted < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            op   = OP_ACK;
            seq  = seq_type'($urandom_range(0, 255));
            if (pick < 60) begin
               // ack one outstanding frame, in any order
               holes.delete();
               for (int unsigned s = sched.base; s < sched.next_seq && s < N_FRAMES; s++)
                  if (!sched.acked[s]) holes.push_back(s);
               if (holes.size() != 0) seq = seq_type'(holes[$urandom_range(0, holes.size() - 1)]);
               else                   op  = OP_START;
            end else if (pick < 65) begin
               // ack a little ahead of what was sent
               tot_pick = sched.next_seq + $urandom_range(0, 4);
               if (tot_pick < sched.total_eff()) seq = seq_type'(tot_pick);
               else                              op  = OP_START;
            end else if (pick < 72) begin
               op = OP_START;
            end else if (pick < 84) begin
               op = OP_TIMEOUT;
            end else if (pick >= 94) begin
               op = OP_UNUSED;
            end
            counted++;
            send_event(op, seq);
            if (!no_gaps) begin
               burst_left--;
               if (burst_left == 0) begin
                  gap = $urandom_range(0, 6);
                  if (gap != 0) hold_off(gap);
                  burst_left = $urandom_range(1, 12);
               end
            end
         end
      end

      // drain, then give stray items time to show up
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sched.mismatches == 0 && sched.frames_due.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
